[rtl/bcia_pkg.sv]
// Shared constants, codes and types of the contiguous slot-ID allocator.
`timescale 1ns / 1ps

package bcia_pkg;

    // Slot store geometry
    localparam int NUM_SLOTS = 1024;
    localparam int WORD_BITS = 32;
    localparam int NUM_WORDS = (NUM_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int SLOT_W    = 10;
    localparam int CNT_W     = 11;

    // Bits of the last word that lie past the end of the store; scanned as used
    localparam logic [WORD_BITS-1:0] TAIL_USED =
        ~({WORD_BITS{1'b1}} >> (NUM_WORDS * WORD_BITS - NUM_SLOTS));

    // Stream payload widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;
    localparam int TUSER_W   = 2;

    // Request kinds
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_RESET = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_NOTHING  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_DONE
    } t_state;

    // Access to the bitmap memory for one cycle
    typedef struct packed {
        logic                 rd_en;
        logic [WADDR_W-1:0]   rd_addr;
        logic                 wr_en;
        logic [WADDR_W-1:0]   wr_addr;
        logic [WORD_BITS-1:0] wr_data;
        logic                 clear;
    } t_mem_cmd;

    // Outcome of evaluating one bitmap word during a first-fit scan
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
        logic [CNT_W-1:0] next_run;
    } t_find;

endpackage

[rtl/bcia_bitmap_mem.sv]
// Bitmap word store: one write and one registered read per cycle, per-word valid bits.
`timescale 1ns / 1ps

module bcia_bitmap_mem (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bcia_pkg::t_mem_cmd                  i_cmd,
    output logic [bcia_pkg::WORD_BITS-1:0]      o_rd_data
);

    logic [bcia_pkg::WORD_BITS-1:0] r_mem [bcia_pkg::NUM_WORDS];
    logic [bcia_pkg::NUM_WORDS-1:0] r_valid;
    logic [bcia_pkg::WORD_BITS-1:0] r_rd_word;
    logic                           r_rd_valid;

    // Write and read the word array
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_word <= r_mem[i_cmd.rd_addr];
        end
    end

    // Track written words; a word never written since a clear reads as all free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_valid <= '0;
            end else if (i_cmd.wr_en) begin
                r_valid[i_cmd.wr_addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_valid <= r_valid[i_cmd.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_word : '0;

endmodule

[rtl/bcia_run_finder.sv]
// Evaluates one bitmap word for a first-fit run, given the free run carried in from below.
`timescale 1ns / 1ps

module bcia_run_finder (
    input  logic [bcia_pkg::WORD_BITS-1:0] i_word,
    input  logic [bcia_pkg::CNT_W-1:0]     i_in_run,
    input  logic [bcia_pkg::CNT_W-1:0]     i_count,
    output bcia_pkg::t_find                o_find
);

    logic [bcia_pkg::WORD_BITS-1:0] pfree;
    logic [bcia_pkg::WORD_BITS-1:0] wfree;
    logic [bcia_pkg::WORD_BITS-1:0] hit;
    logic [bcia_pkg::WORD_BITS-1:0] ones_cnt;
    logic [bcia_pkg::WORD_BITS-1:0] pre_mask;
    logic [bcia_pkg::WORD_BITS-1:0] win_mask;
    logic                           cnt_small;
    logic signed [bcia_pkg::CNT_W+1:0] need;
    logic [5:0]                     sh;
    logic [bcia_pkg::BIT_W-1:0]     pos;
    logic [bcia_pkg::BIT_W-1:0]     lead;
    logic [bcia_pkg::CNT_W:0]       run_sum;

    always_comb begin
        // Slots still needed beyond the carried run, minus one
        need      = $signed({2'b00, i_count}) - $signed({2'b00, i_in_run})
                    - $signed((bcia_pkg::CNT_W+2)'(1));
        cnt_small = (i_count <= bcia_pkg::CNT_W'(bcia_pkg::WORD_BITS));
        ones_cnt  = {bcia_pkg::WORD_BITS{1'b1}} >> (6'd32 - i_count[5:0]);
        pre_mask  = '0;
        win_mask  = '0;
        sh        = '0;

        // Per bit: does a run of the requested length end here
        for (int j = 0; j < bcia_pkg::WORD_BITS; j++) begin
            pre_mask = {bcia_pkg::WORD_BITS{1'b1}} >> (bcia_pkg::BIT_W'(bcia_pkg::WORD_BITS - 1 - j));
            pfree[j] = ((i_word & pre_mask) == '0)
                       && (need <= $signed((bcia_pkg::CNT_W+2)'(j)));
            sh       = 6'(j + 1) - i_count[5:0];
            win_mask = ones_cnt << sh[bcia_pkg::BIT_W-1:0];
            wfree[j] = cnt_small && (bcia_pkg::CNT_W'(j + 1) >= i_count)
                       && ((i_word & win_mask) == '0);
        end
        hit = pfree | wfree;

        // Lowest completing position
        pos = '0;
        for (int j = bcia_pkg::WORD_BITS - 1; j >= 0; j--) begin
            if (hit[j]) begin
                pos = bcia_pkg::BIT_W'(j);
            end
        end

        // Free run left at the top of the word for the next word
        lead = '0;
        for (int j = 0; j < bcia_pkg::WORD_BITS; j++) begin
            if (i_word[j]) begin
                lead = bcia_pkg::BIT_W'(bcia_pkg::WORD_BITS - 1 - j);
            end
        end
        run_sum = {1'b0, i_in_run} + (bcia_pkg::CNT_W+1)'(bcia_pkg::WORD_BITS);

        o_find.found = |hit;
        o_find.pos   = pos;
        if (i_word == '0) begin
            o_find.next_run = run_sum[bcia_pkg::CNT_W] ? '1 : run_sum[bcia_pkg::CNT_W-1:0];
        end else begin
            o_find.next_run = bcia_pkg::CNT_W'(lead);
        end
    end

endmodule

[rtl/bitmap_contiguous_id_allocator.sv]
// Top level of the first-fit contiguous slot-ID allocator.
`timescale 1ns / 1ps

// Keeps 1024 slot IDs as a bitmap of 32 words of 32 bits in one synchronous memory
// plus a count of slots in use. One request is worked on at a time; the next
// request is taken while the previous result still waits on the output side.
// Allocate reads the words from slot 0 up, one per cycle, and stops at the first
// word in which a free run of the requested length completes; it then reads and
// rewrites every word the run touches, one per cycle. A failed allocation scans
// every word. A free reads and rewrites the touched words. Reset, zero counts and
// unknown requests go straight to the result. A reset request clears the per-word
// valid bits at once, no clearing pass is needed.
module bitmap_contiguous_id_allocator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [bcia_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,  // start_slot, slot_count
    input  logic [bcia_pkg::TUSER_W-1:0]       i_s_axis_tuser,  // req_type
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [bcia_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,  // first_slot, used_slots
    output logic [bcia_pkg::TUSER_W-1:0]       o_m_axis_tuser   // status
);

    localparam int SW = bcia_pkg::SLOT_W;
    localparam int CW = bcia_pkg::CNT_W;
    localparam int AW = bcia_pkg::WADDR_W;
    localparam int BW = bcia_pkg::BIT_W;
    localparam int WB = bcia_pkg::WORD_BITS;

    bcia_pkg::t_state     r_state, n_state;
    logic                 r_is_free, n_is_free;
    logic [CW-1:0]        r_count, n_count;
    logic [SW-1:0]        r_lo, n_lo;
    logic [SW-1:0]        r_hi, n_hi;
    logic [CW-1:0]        r_run, n_run;
    logic [AW-1:0]        r_rd_idx, n_rd_idx;
    logic                 r_issue_done, n_issue_done;
    logic                 r_dv, n_dv;
    logic [AW-1:0]        r_dv_idx, n_dv_idx;
    logic [CW-1:0]        r_used, n_used;
    logic [1:0]           r_status, n_status;
    logic [SW-1:0]        r_first, n_first;
    logic                 r_out_valid;
    logic [1:0]           r_out_status;
    logic [SW-1:0]        r_out_first;
    logic [CW-1:0]        r_out_used;

    bcia_pkg::t_mem_cmd   mem_cmd;
    bcia_pkg::t_find      find;
    logic [WB-1:0]        rd_data;
    logic [WB-1:0]        scan_word;
    logic                 in_acc;
    logic                 out_load;
    logic [1:0]           in_req;
    logic [SW-1:0]        in_start;
    logic [CW-1:0]        in_cnt;
    logic [CW:0]          free_end;
    logic [CW:0]          alloc_sum;
    logic [CW-1:0]        alloc_first;
    logic [AW-1:0]        end_idx;
    logic                 issue;
    logic [BW-1:0]        lo_b;
    logic [BW-1:0]        hi_b;
    logic [WB-1:0]        range_mask;

    bcia_bitmap_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (mem_cmd),
        .o_rd_data (rd_data)
    );

    // Treat slots past the end of the store as used while scanning
    assign scan_word = (r_dv_idx == AW'(bcia_pkg::NUM_WORDS - 1))
                       ? (rd_data | bcia_pkg::TAIL_USED) : rd_data;

    bcia_run_finder u_finder (
        .i_word   (scan_word),
        .i_in_run (r_run),
        .i_count  (r_count),
        .o_find   (find)
    );

    // Unpack the request item
    assign in_req   = i_s_axis_tuser;
    assign in_start = i_s_axis_tdata[SW-1:0];
    assign in_cnt   = i_s_axis_tdata[SW+CW-1:SW];

    assign o_s_axis_tready = (r_state == bcia_pkg::S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load        = (r_state == bcia_pkg::S_DONE) && (!r_out_valid || i_m_axis_tready);

    // Range arithmetic for free, allocate and the per-word bit mask
    assign free_end    = (CW+1)'(in_start) + (CW+1)'(in_cnt);
    assign alloc_sum   = {1'b0, r_used} + {1'b0, r_count};
    assign alloc_first = CW'({r_dv_idx, find.pos}) + CW'(1) - r_count;
    assign end_idx     = (r_state == bcia_pkg::S_SCAN) ? AW'(bcia_pkg::NUM_WORDS - 1)
                                                       : r_hi[SW-1:BW];
    assign issue       = ((r_state == bcia_pkg::S_SCAN) || (r_state == bcia_pkg::S_MARK))
                         && !r_issue_done;
    assign lo_b        = (r_dv_idx == r_lo[SW-1:BW]) ? r_lo[BW-1:0] : '0;
    assign hi_b        = (r_dv_idx == r_hi[SW-1:BW]) ? r_hi[BW-1:0] : '1;
    assign range_mask  = ({WB{1'b1}} >> (BW'(WB - 1) - hi_b)) & ({WB{1'b1}} << lo_b);

    // Next state, memory accesses and result
    always_comb begin
        n_state      = r_state;
        n_is_free    = r_is_free;
        n_count      = r_count;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_run        = r_run;
        n_rd_idx     = r_rd_idx;
        n_issue_done = r_issue_done;
        n_dv         = 1'b0;
        n_dv_idx     = r_dv_idx;
        n_used       = r_used;
        n_status     = r_status;
        n_first      = r_first;
        mem_cmd      = '0;

        // Keep one word read in flight while sweeping
        if (issue) begin
            mem_cmd.rd_en   = 1'b1;
            mem_cmd.rd_addr = r_rd_idx;
            n_dv            = 1'b1;
            n_dv_idx        = r_rd_idx;
            if (r_rd_idx == end_idx) begin
                n_issue_done = 1'b1;
            end else begin
                n_rd_idx = r_rd_idx + AW'(1);
            end
        end

        case (r_state)
            bcia_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_count      = in_cnt;
                    n_first      = '0;
                    n_run        = '0;
                    n_rd_idx     = '0;
                    n_issue_done = 1'b0;
                    n_status     = bcia_pkg::ST_NOTHING;
                    n_state      = bcia_pkg::S_DONE;
                    case (in_req)
                        bcia_pkg::REQ_ALLOC: begin
                            if (in_cnt != '0) begin
                                n_is_free = 1'b0;
                                n_state   = bcia_pkg::S_SCAN;
                            end
                        end
                        bcia_pkg::REQ_FREE: begin
                            if ((in_cnt != '0)
                                && ((CW)'(in_start) < CW'(bcia_pkg::NUM_SLOTS))) begin
                                n_is_free = 1'b1;
                                n_lo      = in_start;
                                n_hi      = (free_end > (CW+1)'(bcia_pkg::NUM_SLOTS))
                                            ? SW'(bcia_pkg::NUM_SLOTS - 1)
                                            : SW'(free_end - (CW+1)'(1));
                                n_rd_idx  = in_start[SW-1:BW];
                                n_used    = (r_used > in_cnt) ? (r_used - in_cnt) : '0;
                                n_status  = bcia_pkg::ST_OK;
                                n_state   = bcia_pkg::S_MARK;
                            end
                        end
                        bcia_pkg::REQ_RESET: begin
                            mem_cmd.clear = 1'b1;
                            n_used        = '0;
                            n_status      = bcia_pkg::ST_OK;
                        end
                        default: begin
                            n_status = bcia_pkg::ST_NOTHING;
                        end
                    endcase
                end
            end

            bcia_pkg::S_SCAN: begin
                if (r_dv) begin
                    if (find.found) begin
                        // Run found: drop the read in flight and mark the run
                        n_lo         = alloc_first[SW-1:0];
                        n_hi         = {r_dv_idx, find.pos};
                        n_first      = alloc_first[SW-1:0];
                        n_rd_idx     = alloc_first[SW-1:BW];
                        n_issue_done = 1'b0;
                        n_dv         = 1'b0;
                        n_used       = alloc_sum[CW] ? '1 : alloc_sum[CW-1:0];
                        n_status     = bcia_pkg::ST_OK;
                        n_state      = bcia_pkg::S_MARK;
                    end else if (r_dv_idx == AW'(bcia_pkg::NUM_WORDS - 1)) begin
                        n_status = bcia_pkg::ST_NO_SPACE;
                        n_first  = '0;
                        n_state  = bcia_pkg::S_DONE;
                    end else begin
                        n_run = find.next_run;
                    end
                end
            end

            bcia_pkg::S_MARK: begin
                // Write back the modified word
                if (r_dv) begin
                    mem_cmd.wr_en   = 1'b1;
                    mem_cmd.wr_addr = r_dv_idx;
                    mem_cmd.wr_data = r_is_free ? (rd_data & ~range_mask)
                                                : (rd_data | range_mask);
                    if (r_dv_idx == r_hi[SW-1:BW]) begin
                        n_state = bcia_pkg::S_DONE;
                    end
                end
            end

            bcia_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = bcia_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = bcia_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bcia_pkg::S_IDLE;
            r_issue_done <= 1'b0;
            r_dv         <= 1'b0;
            r_used       <= '0;
        end else begin
            r_state      <= n_state;
            r_issue_done <= n_issue_done;
            r_dv         <= n_dv;
            r_used       <= n_used;
        end
    end

    // Working registers of the current request
    always_ff @(posedge i_clk) begin
        r_is_free <= n_is_free;
        r_count   <= n_count;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_run     <= n_run;
        r_rd_idx  <= n_rd_idx;
        r_dv_idx  <= n_dv_idx;
        r_status  <= n_status;
        r_first   <= n_first;
    end

    // Output register: hold the result item until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_status;
            r_out_first  <= r_first;
            r_out_used   <= r_used;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {{(bcia_pkg::M_TDATA_W - SW - CW){1'b0}}, r_out_used, r_out_first};

endmodule

[bench/bitmap_contiguous_id_allocator_tb.sv]
// Self-checking stream bench for the bitmap first-fit contiguous slot-ID allocator.
`timescale 1ns / 1ps

module bitmap_contiguous_id_allocator_tb;
    import bcia_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int CNT_MAX      = (1 << CNT_W) - 1;
    localparam int RANDOM_ITEMS = 800;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 120;
    localparam int PAD_W        = S_TDATA_W - SLOT_W - CNT_W;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] first_slot;
        logic [CNT_W-1:0]  used_slots;
    } alloc_result_t;

    typedef struct packed {
        logic [1:0]        req;
        logic [SLOT_W-1:0] start_slot;
        logic [CNT_W-1:0]  slot_count;
        logic              typed;
        alloc_result_t     want;
    } directed_row_t;

    typedef struct packed {
        logic [SLOT_W-1:0] first_slot;
        logic [CNT_W-1:0]  slot_count;
    } slot_run_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata;  // start_slot, slot_count
    logic [TUSER_W-1:0]   i_s_axis_tuser;  // req_type
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;  // first_slot, used_slots
    logic [TUSER_W-1:0]   o_m_axis_tuser;  // status

    // Shadow copy of the slot store and the in-use count
    bit [NUM_SLOTS-1:0] slot_map;
    int                 used_count;

    alloc_result_t pending_results[$];
    slot_run_t     live_runs[$];
    int            items_sent;
    int            n_errors;
    bit            tx_burst;

    // Directed requests; expected results typed only where obvious
    directed_row_t directed_plan [25] = '{
        '{REQ_ALLOC,   10'd0,    11'd0,    1'b1, '{ST_NOTHING,  10'd0,   11'd0}},
        '{REQ_FREE,    10'd0,    11'd0,    1'b1, '{ST_NOTHING,  10'd0,   11'd0}},
        '{REQ_ALLOC,   10'd0,    11'd1,    1'b1, '{ST_OK,       10'd0,   11'd1}},
        '{REQ_ALLOC,   10'd0,    11'd31,   1'b1, '{ST_OK,       10'd1,   11'd32}},
        '{REQ_ALLOC,   10'd0,    11'd2,    1'b1, '{ST_OK,       10'd32,  11'd34}},
        '{REQ_FREE,    10'd1,    11'd31,   1'b1, '{ST_OK,       10'd0,   11'd3}},
        '{REQ_ALLOC,   10'd0,    11'd40,   1'b1, '{ST_OK,       10'd34,  11'd43}},
        '{REQ_ALLOC,   10'd0,    11'd1025, 1'b1, '{ST_NO_SPACE, 10'd0,   11'd43}},
        '{REQ_ALLOC,   10'd1023, 11'd2047, 1'b1, '{ST_NO_SPACE, 10'd0,   11'd43}},
        '{REQ_UNKNOWN, 10'd1023, 11'd2047, 1'b1, '{ST_NOTHING,  10'd0,   11'd43}},
        '{REQ_FREE,    10'd1023, 11'd2047, 1'b1, '{ST_OK,       10'd0,   11'd0}},
        '{REQ_FREE,    10'd0,    11'd1,    1'b1, '{ST_OK,       10'd0,   11'd0}},
        '{REQ_ALLOC,   10'd0,    11'd1,    1'b1, '{ST_OK,       10'd0,   11'd1}},
        '{REQ_ALLOC,   10'd0,    11'd1000, 1'b1, '{ST_NO_SPACE, 10'd0,   11'd1}},
        '{REQ_RESET,   10'd0,    11'd0,    1'b1, '{ST_OK,       10'd0,   11'd0}},
        '{REQ_ALLOC,   10'd0,    11'd1024, 1'b1, '{ST_OK,       10'd0,   11'd1024}},
        '{REQ_ALLOC,   10'd0,    11'd1,    1'b1, '{ST_NO_SPACE, 10'd0,   11'd1024}},
        '{REQ_FREE,    10'd512,  11'd1,    1'b1, '{ST_OK,       10'd0,   11'd1023}},
        '{REQ_ALLOC,   10'd0,    11'd1,    1'b1, '{ST_OK,       10'd512, 11'd1024}},
        '{REQ_FREE,    10'd0,    11'd1024, 1'b1, '{ST_OK,       10'd0,   11'd0}},
        '{REQ_ALLOC,   10'd0,    11'd33,   1'b0, '0},
        '{REQ_ALLOC,   10'd1023, 11'd31,   1'b0, '0},
        '{REQ_FREE,    10'd40,   11'd10,   1'b0, '0},
        '{REQ_ALLOC,   10'd0,    11'd5,    1'b0, '0},
        '{REQ_RESET,   10'd1023, 11'd2047, 1'b1, '{ST_OK,       10'd0,   11'd0}}
    };

    bitmap_contiguous_id_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Apply one request to the shadow store and return the answer it gets
    function automatic alloc_result_t predict_request(input logic [1:0] req,
                                                      input logic [SLOT_W-1:0] start,
                                                      input logic [CNT_W-1:0] cnt);
        alloc_result_t r;
        int run;
        int s;
        int end_slot;
        bit found;
        r.status     = ST_NOTHING;
        r.first_slot = '0;
        run          = 0;
        found        = 1'b0;
        case (req)
            REQ_ALLOC: begin
                if (cnt != 0) begin
                    r.status = ST_NO_SPACE;
                    // first fit from slot 0, runs may cross word boundaries
                    if (int'(cnt) <= NUM_SLOTS) begin
                        for (s = 0; s < NUM_SLOTS && !found; s++) begin
                            if (slot_map[s]) begin
                                run = 0;
                            end else begin
                                run++;
                                if (run == int'(cnt)) begin
                                    r.first_slot = SLOT_W'(s + 1 - int'(cnt));
                                    found = 1'b1;
                                end
                            end
                        end
                    end
                    if (found) begin
                        for (s = int'(r.first_slot); s < int'(r.first_slot) + int'(cnt); s++)
                            slot_map[s] = 1'b1;
                        used_count = (used_count + int'(cnt) > CNT_MAX) ?
                                     CNT_MAX : used_count + int'(cnt);
                        r.status = ST_OK;
                    end
                end
            end
            REQ_FREE: begin
                if (cnt != 0 && int'(start) < NUM_SLOTS) begin
                    // clear only inside the store, lower the count by the full amount
                    end_slot = int'(start) + int'(cnt);
                    if (end_slot > NUM_SLOTS)
                        end_slot = NUM_SLOTS;
                    for (s = int'(start); s < end_slot; s++)
                        slot_map[s] = 1'b0;
                    used_count = (used_count > int'(cnt)) ? used_count - int'(cnt) : 0;
                    r.status = ST_OK;
                end
            end
            REQ_RESET: begin
                slot_map   = '0;
                used_count = 0;
                r.status   = ST_OK;
            end
            default: ;
        endcase
        r.used_slots = CNT_W'(used_count);
        return r;
    endfunction

    // Offer one item after a random gap, record its expected result once accepted
    task automatic offer_request(input logic [1:0] req, input logic [SLOT_W-1:0] start,
                                 input logic [CNT_W-1:0] cnt, input logic typed,
                                 input alloc_result_t want);
        alloc_result_t predicted;
        int gap;
        if ($urandom_range(0, 24) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{PAD_W{1'b0}}, cnt, start};
        i_s_axis_tuser  <= req;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        predicted = predict_request(req, start, cnt);
        pending_results.push_back(typed ? want : predicted);
        if (req == REQ_ALLOC && predicted.status == ST_OK)
            live_runs.push_back('{predicted.first_slot, cnt});
        else if (req == REQ_RESET)
            live_runs.delete();
        items_sent++;
        @(negedge i_clk);
    endtask

    // Mostly allocate/free pairs on live runs, the rest noise and odd requests
    task automatic offer_random_request();
        int pick;
        int idx;
        int size_pick;
        slot_run_t run;
        logic [1:0] req;
        logic [SLOT_W-1:0] start;
        logic [CNT_W-1:0] cnt;
        pick  = $urandom_range(0, 99);
        start = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        cnt   = CNT_W'($urandom_range(0, CNT_MAX));
        req   = REQ_ALLOC;
        if (pick >= 45 && pick < 85 && live_runs.size() > 0) begin
            idx = $urandom_range(0, live_runs.size() - 1);
            run = live_runs[idx];
            live_runs.delete(idx);
            req   = REQ_FREE;
            start = run.first_slot;
            cnt   = run.slot_count;
        end else if (pick >= 85 && pick < 90) begin
            req = REQ_FREE;
        end else if (pick >= 90 && pick < 94) begin
            req = pick[0] ? REQ_FREE : REQ_ALLOC;
            cnt = '0;
        end else if (pick >= 94 && pick < 97) begin
            req = REQ_UNKNOWN;
        end else if (pick >= 97) begin
            req = REQ_RESET;
        end else begin
            size_pick = $urandom_range(0, 49);
            if (size_pick < 45)
                cnt = CNT_W'($urandom_range(1, 40));
            else if (size_pick < 49)
                cnt = CNT_W'($urandom_range(41, 300));
            else
                cnt = CNT_W'($urandom_range(301, CNT_MAX));
        end
        offer_request(req, start, cnt, 1'b0, '0);
    endtask

    // Drive requests, then drain and report
    initial begin : stimulus
        int i;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        slot_map        = '0;
        used_count      = 0;
        items_sent      = 0;
        n_errors        = 0;
        tx_burst        = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (i = 0; i < 25; i++)
            offer_request(directed_plan[i].req, directed_plan[i].start_slot,
                          directed_plan[i].slot_count, directed_plan[i].typed,
                          directed_plan[i].want);
        for (i = 0; i < RANDOM_ITEMS; i++)
            offer_random_request();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Take results with random stalls, one long hold-off, and compare each
    initial begin : result_sink
        alloc_result_t seen;
        alloc_result_t want;
        int gap;
        int hold;
        bit rx_burst;
        bit held;
        i_m_axis_tready = 1'b0;
        rx_burst        = 1'b0;
        held            = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (!held && items_sent >= HOLD_AFTER) begin
                // hold off long enough for the block to back up its input
                held = 1'b1;
                hold = 0;
                i_m_axis_tready <= 1'b0;
                while (hold < HOLD_CYCLES) begin
                    @(negedge i_clk);
                    hold++;
                end
            end else begin
                if ($urandom_range(0, 24) == 0)
                    rx_burst = !rx_burst;
                gap = rx_burst ? 0 : $urandom_range(0, 8);
                if (gap > 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid)
                @(posedge i_clk);
            seen.status     = o_m_axis_tuser;
            seen.first_slot = o_m_axis_tdata[SLOT_W-1:0];
            seen.used_slots = o_m_axis_tdata[SLOT_W+CNT_W-1:SLOT_W];
            if (pending_results.size() == 0) begin
                $error("result with no request pending: tuser %0d tdata 0x%06h",
                       o_m_axis_tuser, o_m_axis_tdata);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (seen.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, seen.status);
                    n_errors++;
                end
                if (seen.first_slot !== want.first_slot) begin
                    $error("first_slot: expected %0d, got %0d",
                           want.first_slot, seen.first_slot);
                    n_errors++;
                end
                if (seen.used_slots !== want.used_slots) begin
                    $error("used_slots: expected %0d, got %0d",
                           want.used_slots, seen.used_slots);
                    n_errors++;
                end
            end
            @(negedge i_clk);
        end
    end

    // End the run if neither side moves an item for too long
    initial begin : stall_watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/bcia_pkg.sv
rtl/bcia_bitmap_mem.sv
rtl/bcia_run_finder.sv
rtl/bitmap_contiguous_id_allocator.sv
bench/bitmap_contiguous_id_allocator_tb.sv
